@@ hdl/ast_pkg.sv @@
`timescale 1ns / 1ps

package ast_pkg;

    localparam int MAX_SEGMENTS  = 64;
    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STEPS  = 30;
    localparam int SEG_CFG_W     = 7;
    localparam int SEG_RESET     = 32;
    localparam int CNT_W         = $clog2(MAX_SEGMENTS + 1);   // holds 0..MAX_SEGMENTS
    localparam int IDX_W         = 6;
    localparam int MAG_W         = ANGLE_BITS + 1;             // |span| up to one turn
    localparam int DVD_W         = MAG_W + 1;                  // 2*|span|
    localparam int DVS_W         = CNT_W + 1;                  // 2*n

    localparam logic signed [31:0] CORDIC_X0 = 32'sh26DD3B6A;
    localparam logic signed [31:0] ONE_Q30   = 32'sh40000000;

    typedef struct packed {
        logic [CNT_W-1:0]  k;
        logic              last;
        logic [1:0]        quad;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [30:0]       r;
    } pt_info_t;

    function automatic logic signed [31:0] atan_phase(input int i);
        logic signed [31:0] v;
        case (i)
            0:  v = 32'sh20000000;  1:  v = 32'sh12E4051E;  2:  v = 32'sh09FB385B;
            3:  v = 32'sh051111D4;  4:  v = 32'sh028B0D43;  5:  v = 32'sh0145D7E1;
            6:  v = 32'sh00A2F61E;  7:  v = 32'sh00517C55;  8:  v = 32'sh0028BE53;
            9:  v = 32'sh00145F2F;  10: v = 32'sh000A2F98;  11: v = 32'sh000517CC;
            12: v = 32'sh00028BE6;  13: v = 32'sh000145F3;  14: v = 32'sh0000A2FA;
            15: v = 32'sh0000517D;  16: v = 32'sh000028BE;  17: v = 32'sh0000145F;
            18: v = 32'sh00000A30;  19: v = 32'sh00000518;  20: v = 32'sh0000028C;
            21: v = 32'sh00000146;  22: v = 32'sh000000A3;  23: v = 32'sh00000051;
            24: v = 32'sh00000029;  25: v = 32'sh00000014;  26: v = 32'sh0000000A;
            27: v = 32'sh00000005;  28: v = 32'sh00000003;  29: v = 32'sh00000001;
            default: v = 32'sh00000000;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/arc_segment_tessellator_unit.sv @@
`timescale 1ns / 1ps
// Arc segment tessellator.
// s_ channel: one beat per arc. s_tdata from bit 0: center_x[31:0], center_y[31:0],
//   radius[30:0], start_angle[15:0], span_angle[17:0], zero pad to 136 bits.
// m_ channel: one beat per chord segment, in order. m_tdata from bit 0: from_x, from_y,
//   to_x, to_y (32 bits each), segment_index[5:0], zero pad to 136 bits.
//   m_tlast marks the final segment of an arc.
// cfg_ channel: cfg_data is segment_count (7 bits), always ready; write only while idle.
// Per arc the sequencer latches the beat, sizes n, runs a restoring divider for the
// angle step, then issues the n+1 endpoint angles one per cycle while the output
// does not stall; the input side takes no new arc until the last angle is issued.
// Endpoints run through a 30 stage CORDIC pipeline, then clamp/quadrant, multiply,
// round and add/saturate stages; within an arc, segments then follow one per cycle
// while m_tready allows.
// Reset (aresetn low, synchronous) empties the pipeline, drops any arc in progress
// and sets segment_count to 32.
// When m_tready is low with a beat pending, the whole pipeline and the angle
// issue freeze together; nothing is lost or repeated.
module arc_segment_tessellator_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // center_x, center_y, radius, start_angle, span_angle
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // from_x, from_y, to_x, to_y, segment_index
    output logic         m_tlast,   // last_segment
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [ast_pkg::SEG_CFG_W-1:0] cfg_data   // segment_count
);
    import ast_pkg::*;

    localparam int PIPE     = CORDIC_STEPS + 4;   // entry, cordic, quad, mul, round, coord
    localparam int Q_ST     = CORDIC_STEPS + 1;
    localparam int R_ST     = CORDIC_STEPS + 3;
    localparam int C_ST     = CORDIC_STEPS + 4;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);
    localparam int PROD_W   = SEG_CFG_W + MAG_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SIZE, ST_DIV, ST_EMIT} seq_state_t;

    // ---------------- configuration
    logic [SEG_CFG_W-1:0] seg_cfg_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_cfg_reg <= SEG_CFG_W'(SEG_RESET);
        end else if (cfg_valid) begin
            seg_cfg_reg <= cfg_data;
        end
    end

    // ---------------- stall control: whole pipe moves when output can take a beat
    logic m_tvalid_reg;
    logic adv;
    assign adv = !m_tvalid_reg || m_tready;

    // ---------------- sequencer
    seq_state_t state_reg;
    logic signed [31:0]     cx_reg, cy_reg;
    logic [30:0]            r_reg;
    logic [ANGLE_BITS-1:0]  start_reg;
    logic                   neg_reg;
    logic [MAG_W-1:0]       mag_reg;
    logic [SEG_CFG_W-1:0]   seg_reg;
    logic [CNT_W-1:0]       n_reg;
    logic [DVD_W-1:0]       dvd_reg;      // dividend shifting out, quotient shifting in
    logic [DVS_W-1:0]       rem_reg;
    logic [DIV_CNT_W-1:0]   dcnt_reg;
    logic [DVD_W-1:0]       acc_q_reg;
    logic [DVS_W-1:0]       acc_r_reg;
    logic [CNT_W-1:0]       k_reg;

    assign s_tready = (state_reg == ST_IDLE);

    logic signed [17:0] in_span;
    logic [18:0]        in_abs;
    logic [MAG_W-1:0]   in_mag;
    logic [SEG_CFG_W-1:0] seg_clamp;
    assign in_span = s_tdata[128:111];
    assign in_abs  = in_span[17] ? 19'(-{in_span[17], in_span}) : 19'({1'b0, in_span});
    assign in_mag  = (in_abs > 19'(1 << ANGLE_BITS)) ? MAG_W'(1 << ANGLE_BITS)
                                                     : in_abs[MAG_W-1:0];
    assign seg_clamp = (seg_cfg_reg == '0) ? SEG_CFG_W'(1) :
                       (seg_cfg_reg > SEG_CFG_W'(MAX_SEGMENTS)) ? SEG_CFG_W'(MAX_SEGMENTS)
                                                                : seg_cfg_reg;

    // n = round(seg * mag / turn), clamped to 1..MAX_SEGMENTS
    logic [PROD_W-1:0] n_prod;
    logic [PROD_W-1:0] n_raw;
    logic [CNT_W-1:0]  n_val;
    assign n_prod = PROD_W'(seg_reg) * PROD_W'(mag_reg) + PROD_W'(1 << (ANGLE_BITS - 1));
    assign n_raw  = n_prod >> ANGLE_BITS;
    assign n_val  = (n_raw == '0) ? CNT_W'(1) :
                    (n_raw > PROD_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : n_raw[CNT_W-1:0];

    logic [DVS_W-1:0] two_n;
    assign two_n = {n_reg, 1'b0};

    // restoring divide step
    logic [DVS_W:0] div_try;
    logic           div_ge;
    assign div_try = {rem_reg, dvd_reg[DVD_W-1]};
    assign div_ge  = div_try >= {1'b0, two_n};

    // step accumulate: quotient in dvd_reg, remainder in rem_reg after divide
    logic [DVS_W:0] acc_sum;
    logic           acc_wrap;
    assign acc_sum  = {1'b0, acc_r_reg} + {1'b0, rem_reg};
    assign acc_wrap = acc_sum >= {1'b0, two_n};

    logic emit;
    assign emit = (state_reg == ST_EMIT) && adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cx_reg    <= s_tdata[31:0];
                        cy_reg    <= s_tdata[63:32];
                        r_reg     <= s_tdata[94:64];
                        start_reg <= s_tdata[110:95];
                        neg_reg   <= in_span[17];
                        mag_reg   <= in_mag;
                        seg_reg   <= seg_clamp;
                        state_reg <= ST_SIZE;
                    end
                end
                ST_SIZE: begin
                    n_reg     <= n_val;
                    dvd_reg   <= {mag_reg, 1'b0};
                    rem_reg   <= '0;
                    dcnt_reg  <= DIV_CNT_W'(DVD_W);
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_ge) begin
                        rem_reg <= DVS_W'(div_try - {1'b0, two_n});
                    end else begin
                        rem_reg <= div_try[DVS_W-1:0];
                    end
                    dvd_reg  <= {dvd_reg[DVD_W-2:0], div_ge};
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == DIV_CNT_W'(1)) begin
                        acc_q_reg <= '0;
                        acc_r_reg <= DVS_W'(n_reg);
                        k_reg     <= '0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (adv) begin
                        if (acc_wrap) begin
                            acc_r_reg <= DVS_W'(acc_sum - {1'b0, two_n});
                            acc_q_reg <= acc_q_reg + dvd_reg + 1'b1;
                        end else begin
                            acc_r_reg <= acc_sum[DVS_W-1:0];
                            acc_q_reg <= acc_q_reg + dvd_reg;
                        end
                        k_reg <= k_reg + 1'b1;
                        if (k_reg == n_reg) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // endpoint angle, wrapped to one turn
    logic [ANGLE_BITS-1:0] pt_angle;
    logic [31:0]           pt_phase;
    assign pt_angle = neg_reg ? (start_reg - acc_q_reg[ANGLE_BITS-1:0])
                              : (start_reg + acc_q_reg[ANGLE_BITS-1:0]);
    assign pt_phase = 32'(pt_angle) << (32 - ANGLE_BITS);

    // ---------------- point pipeline
    logic               vld_reg  [0:PIPE];
    pt_info_t           info_reg [0:PIPE];
    logic signed [31:0] x_reg    [0:CORDIC_STEPS];
    logic signed [31:0] y_reg    [0:CORDIC_STEPS];
    logic signed [31:0] z_reg    [0:CORDIC_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= PIPE; j++) begin
                vld_reg[j] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= emit;
            for (int j = 1; j <= PIPE; j++) begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            info_reg[0].k    <= k_reg;
            info_reg[0].last <= (k_reg == n_reg);
            info_reg[0].quad <= pt_phase[31:30];
            info_reg[0].cx   <= cx_reg;
            info_reg[0].cy   <= cy_reg;
            info_reg[0].r    <= r_reg;
            x_reg[0] <= CORDIC_X0;
            y_reg[0] <= '0;
            z_reg[0] <= {2'b00, pt_phase[29:0]};
            for (int j = 1; j <= PIPE; j++) begin
                info_reg[j] <= info_reg[j-1];
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (!z_reg[i][31]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_phase(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_phase(i);
                end
            end
        end
    end

    // clamp and quadrant fold
    logic signed [31:0] xc, yc;
    assign xc = (x_reg[CORDIC_STEPS] > ONE_Q30) ? ONE_Q30 :
                (x_reg[CORDIC_STEPS] < -ONE_Q30) ? -ONE_Q30 : x_reg[CORDIC_STEPS];
    assign yc = (y_reg[CORDIC_STEPS] > ONE_Q30) ? ONE_Q30 :
                (y_reg[CORDIC_STEPS] < -ONE_Q30) ? -ONE_Q30 : y_reg[CORDIC_STEPS];

    logic signed [31:0] cos_reg, sin_reg;
    logic signed [63:0] px_reg, py_reg;
    logic signed [33:0] rx_reg, ry_reg;
    logic signed [31:0] ox_reg, oy_reg;

    logic signed [63:0] px_rnd, py_rnd;
    logic signed [34:0] sx, sy;
    assign px_rnd = px_reg + 64'sd536870912;
    assign py_rnd = py_reg + 64'sd536870912;
    assign sx = 35'(info_reg[R_ST].cx) + 35'(rx_reg);
    assign sy = 35'(info_reg[R_ST].cy) + 35'(ry_reg);

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -35'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (adv) begin
            case (info_reg[CORDIC_STEPS].quad)
                2'd0: begin cos_reg <= xc;  sin_reg <= yc;  end
                2'd1: begin cos_reg <= -yc; sin_reg <= xc;  end
                2'd2: begin cos_reg <= -xc; sin_reg <= -yc; end
                default: begin cos_reg <= yc; sin_reg <= -xc; end
            endcase
            px_reg <= 64'(signed'({1'b0, info_reg[Q_ST].r})) * 64'(cos_reg);
            py_reg <= 64'(signed'({1'b0, info_reg[Q_ST].r})) * 64'(sin_reg);
            rx_reg <= 34'(px_rnd >>> 30);
            ry_reg <= 34'(py_rnd >>> 30);
            ox_reg <= sat32(sx);
            oy_reg <= sat32(sy);
        end
    end

    // ---------------- pair consecutive endpoints into segments
    logic signed [31:0] prev_x_reg, prev_y_reg;
    logic signed [31:0] from_x_reg, from_y_reg, to_x_reg, to_y_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               last_reg;
    logic [CNT_W-1:0]   c_k;
    assign c_k = info_reg[C_ST].k;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= vld_reg[C_ST] && (c_k != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && vld_reg[C_ST]) begin
            prev_x_reg <= ox_reg;
            prev_y_reg <= oy_reg;
            from_x_reg <= prev_x_reg;
            from_y_reg <= prev_y_reg;
            to_x_reg   <= ox_reg;
            to_y_reg   <= oy_reg;
            idx_reg    <= IDX_W'(c_k - 1'b1);
            last_reg   <= info_reg[C_ST].last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {2'b00, idx_reg, to_y_reg, to_x_reg, from_y_reg, from_x_reg};

endmodule
